// ===== rtl/core/abkf_pkg.sv =====
// shared types, constants and helpers of the angle/bias kalman filter
package abkf_pkg;

    localparam int unsigned DataW  = 32;
    localparam int unsigned NoiseW = 25;
    localparam int unsigned DtW    = 17;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned MulAW  = 36;
    localparam int unsigned MulBW  = 33;
    localparam int unsigned ProdW  = MulAW + MulBW;
    localparam int unsigned RndW   = 56;
    localparam int unsigned WideW  = 72;
    localparam int unsigned DvdW   = 57;
    localparam int unsigned RemW   = 36;
    localparam int unsigned DivCntW = 6;

    localparam logic signed [DataW-1:0] OneQ24 = 32'sd16777216;

    localparam logic [NoiseW-1:0] QAngleRst = 25'd16777;
    localparam logic [NoiseW-1:0] QBiasRst  = 25'd50332;
    localparam logic [NoiseW-1:0] RMeasRst  = 25'd503316;
    localparam logic [DtW-1:0]    DtRst     = 17'd6554;

    localparam logic [CfgIdxW-1:0] RegQAngle = 3'd0;
    localparam logic [CfgIdxW-1:0] RegQBias  = 3'd1;
    localparam logic [CfgIdxW-1:0] RegRMeas  = 3'd2;
    localparam logic [CfgIdxW-1:0] RegDt     = 3'd3;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_RATE,
        CMD_MUL_RATE_DT,
        CMD_MUL_P11_DT,
        CMD_MUL_T_DT,
        CMD_MUL_QB_DT,
        CMD_MUL_K0_Y,
        CMD_MUL_K1_Y,
        CMD_MUL_K1_P00,
        CMD_MUL_K0_P00,
        CMD_MUL_K1_P01,
        CMD_MUL_K0_P01,
        CMD_RND16,
        CMD_RND24,
        CMD_ANG_ADD,
        CMD_DTP11,
        CMD_P00_ADD,
        CMD_P11_ADD,
        CMD_DIV_INIT,
        CMD_DIV_STEP,
        CMD_DIV_END,
        CMD_BIAS_ADD,
        CMD_P00_SUB,
        CMD_P01_SUB,
        CMD_P10_SUB,
        CMD_P11_SUB,
        CMD_STORE
    } t_cmd;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_RATE,
        ST_M_RATE, ST_R_RATE, ST_ANG,
        ST_M_P11, ST_R_P11, ST_DTP,
        ST_M_T, ST_R_T, ST_P00A,
        ST_M_QB, ST_R_QB, ST_P11A,
        ST_DIV_INIT, ST_DIV, ST_DIV_END,
        ST_M_K0Y, ST_R_K0Y, ST_ACORR,
        ST_M_K1Y, ST_R_K1Y, ST_BCORR,
        ST_M_K1P00, ST_R_K1P00, ST_SP10,
        ST_M_K0P00, ST_R_K0P00, ST_SP00,
        ST_M_K1P01, ST_R_K1P01, ST_SP11,
        ST_M_K0P01, ST_R_K0P01, ST_SP01,
        ST_STORE
    } t_state;

    typedef struct packed {
        logic ch_ok;
        logic s_pos;
        logic div_last;
    } t_status;

    function automatic logic signed [DataW-1:0] sat32(input logic signed [WideW-1:0] v);
        if (v > 72'sh7FFFFFFF) begin
            return 32'sh7FFFFFFF;
        end else if (v < -72'sh80000000) begin
            return -32'sh80000000;
        end
        return v[DataW-1:0];
    endfunction

    // rescale by 2^16 or 2^24, rounding half away from zero
    function automatic logic signed [RndW-1:0] round_shift(
        input logic signed [ProdW-1:0] v,
        input logic sel24
    );
        logic [ProdW-1:0] mag;
        logic [ProdW-1:0] sum;
        logic [ProdW-1:0] sh;
        mag = v[ProdW-1] ? ProdW'(-v) : ProdW'(v);
        sum = mag + (sel24 ? (ProdW'(1) << 23) : (ProdW'(1) << 15));
        sh  = sel24 ? (sum >> 24) : (sum >> 16);
        return v[ProdW-1] ? -$signed(RndW'(sh)) : $signed(RndW'(sh));
    endfunction

endpackage

// ===== rtl/core/abkf_ctrl.sv =====
// sequencer that steps the datapath through predict, gain and correct
module abkf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  abkf_pkg::t_status i_status,
    output abkf_pkg::t_cmd    o_cmd
);

    abkf_pkg::t_state r_state, n_state;
    logic r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= abkf_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = abkf_pkg::CMD_NONE;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            abkf_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd   = abkf_pkg::CMD_LOAD;
                    n_state = abkf_pkg::ST_RATE;
                end
            end
            abkf_pkg::ST_RATE: begin
                o_cmd   = abkf_pkg::CMD_RATE;
                n_state = i_status.ch_ok ? abkf_pkg::ST_M_RATE : abkf_pkg::ST_STORE;
            end
            abkf_pkg::ST_M_RATE: begin
                o_cmd = abkf_pkg::CMD_MUL_RATE_DT; n_state = abkf_pkg::ST_R_RATE;
            end
            abkf_pkg::ST_R_RATE: begin
                o_cmd = abkf_pkg::CMD_RND16; n_state = abkf_pkg::ST_ANG;
            end
            abkf_pkg::ST_ANG: begin
                o_cmd = abkf_pkg::CMD_ANG_ADD; n_state = abkf_pkg::ST_M_P11;
            end
            abkf_pkg::ST_M_P11: begin
                o_cmd = abkf_pkg::CMD_MUL_P11_DT; n_state = abkf_pkg::ST_R_P11;
            end
            abkf_pkg::ST_R_P11: begin
                o_cmd = abkf_pkg::CMD_RND16; n_state = abkf_pkg::ST_DTP;
            end
            abkf_pkg::ST_DTP: begin
                o_cmd = abkf_pkg::CMD_DTP11; n_state = abkf_pkg::ST_M_T;
            end
            abkf_pkg::ST_M_T: begin
                o_cmd = abkf_pkg::CMD_MUL_T_DT; n_state = abkf_pkg::ST_R_T;
            end
            abkf_pkg::ST_R_T: begin
                o_cmd = abkf_pkg::CMD_RND16; n_state = abkf_pkg::ST_P00A;
            end
            abkf_pkg::ST_P00A: begin
                o_cmd = abkf_pkg::CMD_P00_ADD; n_state = abkf_pkg::ST_M_QB;
            end
            abkf_pkg::ST_M_QB: begin
                o_cmd = abkf_pkg::CMD_MUL_QB_DT; n_state = abkf_pkg::ST_R_QB;
            end
            abkf_pkg::ST_R_QB: begin
                o_cmd = abkf_pkg::CMD_RND16; n_state = abkf_pkg::ST_P11A;
            end
            abkf_pkg::ST_P11A: begin
                o_cmd = abkf_pkg::CMD_P11_ADD; n_state = abkf_pkg::ST_DIV_INIT;
            end
            abkf_pkg::ST_DIV_INIT: begin
                o_cmd   = abkf_pkg::CMD_DIV_INIT;
                n_state = i_status.s_pos ? abkf_pkg::ST_DIV : abkf_pkg::ST_STORE;
            end
            abkf_pkg::ST_DIV: begin
                o_cmd = abkf_pkg::CMD_DIV_STEP;
                if (i_status.div_last) begin
                    n_state = abkf_pkg::ST_DIV_END;
                end
            end
            abkf_pkg::ST_DIV_END: begin
                o_cmd = abkf_pkg::CMD_DIV_END; n_state = abkf_pkg::ST_M_K0Y;
            end
            abkf_pkg::ST_M_K0Y: begin
                o_cmd = abkf_pkg::CMD_MUL_K0_Y; n_state = abkf_pkg::ST_R_K0Y;
            end
            abkf_pkg::ST_R_K0Y: begin
                o_cmd = abkf_pkg::CMD_RND24; n_state = abkf_pkg::ST_ACORR;
            end
            abkf_pkg::ST_ACORR: begin
                o_cmd = abkf_pkg::CMD_ANG_ADD; n_state = abkf_pkg::ST_M_K1Y;
            end
            abkf_pkg::ST_M_K1Y: begin
                o_cmd = abkf_pkg::CMD_MUL_K1_Y; n_state = abkf_pkg::ST_R_K1Y;
            end
            abkf_pkg::ST_R_K1Y: begin
                o_cmd = abkf_pkg::CMD_RND24; n_state = abkf_pkg::ST_BCORR;
            end
            abkf_pkg::ST_BCORR: begin
                o_cmd = abkf_pkg::CMD_BIAS_ADD; n_state = abkf_pkg::ST_M_K1P00;
            end
            // each product reads its covariance term before that term is updated
            abkf_pkg::ST_M_K1P00: begin
                o_cmd = abkf_pkg::CMD_MUL_K1_P00; n_state = abkf_pkg::ST_R_K1P00;
            end
            abkf_pkg::ST_R_K1P00: begin
                o_cmd = abkf_pkg::CMD_RND24; n_state = abkf_pkg::ST_SP10;
            end
            abkf_pkg::ST_SP10: begin
                o_cmd = abkf_pkg::CMD_P10_SUB; n_state = abkf_pkg::ST_M_K0P00;
            end
            abkf_pkg::ST_M_K0P00: begin
                o_cmd = abkf_pkg::CMD_MUL_K0_P00; n_state = abkf_pkg::ST_R_K0P00;
            end
            abkf_pkg::ST_R_K0P00: begin
                o_cmd = abkf_pkg::CMD_RND24; n_state = abkf_pkg::ST_SP00;
            end
            abkf_pkg::ST_SP00: begin
                o_cmd = abkf_pkg::CMD_P00_SUB; n_state = abkf_pkg::ST_M_K1P01;
            end
            abkf_pkg::ST_M_K1P01: begin
                o_cmd = abkf_pkg::CMD_MUL_K1_P01; n_state = abkf_pkg::ST_R_K1P01;
            end
            abkf_pkg::ST_R_K1P01: begin
                o_cmd = abkf_pkg::CMD_RND24; n_state = abkf_pkg::ST_SP11;
            end
            abkf_pkg::ST_SP11: begin
                o_cmd = abkf_pkg::CMD_P11_SUB; n_state = abkf_pkg::ST_M_K0P01;
            end
            abkf_pkg::ST_M_K0P01: begin
                o_cmd = abkf_pkg::CMD_MUL_K0_P01; n_state = abkf_pkg::ST_R_K0P01;
            end
            abkf_pkg::ST_R_K0P01: begin
                o_cmd = abkf_pkg::CMD_RND24; n_state = abkf_pkg::ST_SP01;
            end
            abkf_pkg::ST_SP01: begin
                o_cmd = abkf_pkg::CMD_P01_SUB; n_state = abkf_pkg::ST_STORE;
            end
            abkf_pkg::ST_STORE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd       = abkf_pkg::CMD_STORE;
                    n_out_valid = 1'b1;
                    n_state     = abkf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = abkf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/abkf_datapath.sv =====
// per-channel state, config registers, shared multiplier and two divider lanes
module abkf_datapath #(
    parameter int CHANNELS = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  abkf_pkg::t_cmd                      i_cmd,
    output abkf_pkg::t_status                   o_status,
    input  logic                                i_cfg_we,
    input  logic [abkf_pkg::CfgIdxW-1:0]        i_cfg_index,
    input  logic [abkf_pkg::NoiseW-1:0]         i_cfg_data,
    input  logic                                i_channel,
    input  logic signed [abkf_pkg::DataW-1:0]   i_measured_angle,
    input  logic signed [abkf_pkg::DataW-1:0]   i_measured_rate,
    output logic                                o_out_channel,
    output logic signed [abkf_pkg::DataW-1:0]   o_angle_estimate,
    output logic signed [abkf_pkg::DataW-1:0]   o_unbiased_rate
);

    localparam int IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DW   = abkf_pkg::DataW;
    localparam int WW   = abkf_pkg::WideW;

    logic [abkf_pkg::NoiseW-1:0] r_q_angle, r_q_bias, r_r_meas;
    logic [abkf_pkg::DtW-1:0]    r_dt;

    logic signed [DW-1:0] mem_ang [CHANNELS];
    logic signed [DW-1:0] mem_bias[CHANNELS];
    logic signed [DW-1:0] mem_p00 [CHANNELS];
    logic signed [DW-1:0] mem_p01 [CHANNELS];
    logic signed [DW-1:0] mem_p10 [CHANNELS];
    logic signed [DW-1:0] mem_p11 [CHANNELS];

    logic                 r_ch, r_ch_ok;
    logic [IdxW-1:0]      r_idx;
    logic signed [DW-1:0] r_meas, r_mrate, r_rate, r_y, r_k0, r_k1;
    logic signed [DW-1:0] r_ang, r_bias, r_p00, r_p01, r_p10, r_p11;
    logic signed [abkf_pkg::MulAW-1:0] r_t;
    logic signed [abkf_pkg::ProdW-1:0] r_prod;
    logic signed [abkf_pkg::RndW-1:0]  r_rnd;

    logic [abkf_pkg::DvdW-1:0]    r_dvd0, r_dvd1;
    logic [abkf_pkg::RemW-1:0]    r_rem0, r_rem1;
    logic [abkf_pkg::RemW-2:0]    r_divisor;
    logic                         r_neg0, r_neg1;
    logic [abkf_pkg::DivCntW-1:0] r_cnt;

    logic                 r_out_ch;
    logic signed [DW-1:0] r_out_ang, r_out_rate;

    logic [IdxW-1:0] in_idx;
    logic            in_ok;
    logic signed [abkf_pkg::MulAW-1:0] mul_a;
    logic signed [abkf_pkg::MulBW-1:0] mul_b;
    logic signed [abkf_pkg::MulBW-1:0] dt_b;
    logic signed [33:0]                s_sum;
    logic [DW-1:0]                     mag0, mag1;
    logic signed [abkf_pkg::MulAW-1:0] dtp_rnd;
    logic [abkf_pkg::RemW:0]           trial0, trial1;

    assign in_idx = IdxW'(i_channel);
    assign in_ok  = (32'(i_channel) < 32'(CHANNELS));
    assign dt_b   = $signed({16'd0, r_dt});
    assign s_sum  = 34'(r_p00) + $signed({9'd0, r_r_meas});
    assign mag0   = r_p00[DW-1] ? DW'(-r_p00) : DW'(r_p00);
    assign mag1   = r_p10[DW-1] ? DW'(-r_p10) : DW'(r_p10);
    assign dtp_rnd = r_rnd[abkf_pkg::MulAW-1:0];

    assign trial0 = {r_rem0[abkf_pkg::RemW-2:0], r_dvd0[abkf_pkg::DvdW-1]}
                    - {2'b00, r_divisor};
    assign trial1 = {r_rem1[abkf_pkg::RemW-2:0], r_dvd1[abkf_pkg::DvdW-1]}
                    - {2'b00, r_divisor};

    assign o_status.ch_ok    = r_ch_ok;
    assign o_status.s_pos    = !s_sum[33] && (s_sum != 34'sd0);
    assign o_status.div_last = (r_cnt == abkf_pkg::DivCntW'(1));

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd)
            abkf_pkg::CMD_MUL_RATE_DT: begin mul_a = 36'(r_rate); mul_b = dt_b; end
            abkf_pkg::CMD_MUL_P11_DT:  begin mul_a = 36'(r_p11);  mul_b = dt_b; end
            abkf_pkg::CMD_MUL_T_DT:    begin mul_a = r_t;         mul_b = dt_b; end
            abkf_pkg::CMD_MUL_QB_DT:   begin
                mul_a = $signed({11'd0, r_q_bias}); mul_b = dt_b;
            end
            abkf_pkg::CMD_MUL_K0_Y:    begin mul_a = 36'(r_k0); mul_b = 33'(r_y);   end
            abkf_pkg::CMD_MUL_K1_Y:    begin mul_a = 36'(r_k1); mul_b = 33'(r_y);   end
            abkf_pkg::CMD_MUL_K1_P00:  begin mul_a = 36'(r_k1); mul_b = 33'(r_p00); end
            abkf_pkg::CMD_MUL_K0_P00:  begin mul_a = 36'(r_k0); mul_b = 33'(r_p00); end
            abkf_pkg::CMD_MUL_K1_P01:  begin mul_a = 36'(r_k1); mul_b = 33'(r_p01); end
            abkf_pkg::CMD_MUL_K0_P01:  begin mul_a = 36'(r_k0); mul_b = 33'(r_p01); end
            default: begin
            end
        endcase
    end

    // quotient above 2^31 saturated to 2^32 in magnitude, then signed and clamped
    function automatic logic signed [DW-1:0] gain(
        input logic [abkf_pkg::DvdW-1:0] q,
        input logic neg
    );
        logic [32:0] m;
        m = (q > 57'd2147483648) ? 33'h100000000 : q[32:0];
        return abkf_pkg::sat32(neg ? -$signed(72'(m)) : $signed(72'(m)));
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_angle <= abkf_pkg::QAngleRst;
            r_q_bias  <= abkf_pkg::QBiasRst;
            r_r_meas  <= abkf_pkg::RMeasRst;
            r_dt      <= abkf_pkg::DtRst;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                abkf_pkg::RegQAngle: r_q_angle <= i_cfg_data;
                abkf_pkg::RegQBias:  r_q_bias  <= i_cfg_data;
                abkf_pkg::RegRMeas:  r_r_meas  <= i_cfg_data;
                abkf_pkg::RegDt:     r_dt      <= i_cfg_data[abkf_pkg::DtW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                mem_ang[i]  <= '0;
                mem_bias[i] <= '0;
                mem_p00[i]  <= abkf_pkg::OneQ24;
                mem_p01[i]  <= '0;
                mem_p10[i]  <= '0;
                mem_p11[i]  <= abkf_pkg::OneQ24;
            end
        end else if (i_cmd == abkf_pkg::CMD_STORE && r_ch_ok) begin
            mem_ang[r_idx]  <= r_ang;
            mem_bias[r_idx] <= r_bias;
            mem_p00[r_idx]  <= r_p00;
            mem_p01[r_idx]  <= r_p01;
            mem_p10[r_idx]  <= r_p10;
            mem_p11[r_idx]  <= r_p11;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch_ok <= 1'b0;
            r_cnt   <= '0;
        end else begin
            unique case (i_cmd)
                abkf_pkg::CMD_LOAD: begin
                    r_ch_ok <= in_ok;
                end
                abkf_pkg::CMD_DIV_INIT: begin
                    r_cnt <= abkf_pkg::DivCntW'(abkf_pkg::DvdW);
                end
                abkf_pkg::CMD_DIV_STEP: begin
                    r_cnt <= r_cnt - abkf_pkg::DivCntW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            abkf_pkg::CMD_LOAD: begin
                r_ch    <= i_channel;
                r_idx   <= in_idx;
                r_meas  <= i_measured_angle;
                r_mrate <= i_measured_rate;
                if (in_ok) begin
                    r_ang  <= mem_ang[in_idx];
                    r_bias <= mem_bias[in_idx];
                    r_p00  <= mem_p00[in_idx];
                    r_p01  <= mem_p01[in_idx];
                    r_p10  <= mem_p10[in_idx];
                    r_p11  <= mem_p11[in_idx];
                end
            end
            abkf_pkg::CMD_RATE: begin
                r_rate <= abkf_pkg::sat32(WW'(r_mrate) - WW'(r_bias));
            end
            abkf_pkg::CMD_MUL_RATE_DT, abkf_pkg::CMD_MUL_P11_DT, abkf_pkg::CMD_MUL_T_DT,
            abkf_pkg::CMD_MUL_QB_DT, abkf_pkg::CMD_MUL_K0_Y, abkf_pkg::CMD_MUL_K1_Y,
            abkf_pkg::CMD_MUL_K1_P00, abkf_pkg::CMD_MUL_K0_P00, abkf_pkg::CMD_MUL_K1_P01,
            abkf_pkg::CMD_MUL_K0_P01: begin
                r_prod <= abkf_pkg::ProdW'(mul_a) * abkf_pkg::ProdW'(mul_b);
            end
            abkf_pkg::CMD_RND16: begin
                r_rnd <= abkf_pkg::round_shift(r_prod, 1'b0);
            end
            abkf_pkg::CMD_RND24: begin
                r_rnd <= abkf_pkg::round_shift(r_prod, 1'b1);
            end
            abkf_pkg::CMD_ANG_ADD: begin
                r_ang <= abkf_pkg::sat32(WW'(r_ang) + WW'(r_rnd));
            end
            abkf_pkg::CMD_DTP11: begin
                // t uses the off-diagonal terms before they are reduced
                r_t   <= dtp_rnd - 36'(r_p01) - 36'(r_p10) + $signed({11'd0, r_q_angle});
                r_p01 <= abkf_pkg::sat32(WW'(r_p01) - WW'(r_rnd));
                r_p10 <= abkf_pkg::sat32(WW'(r_p10) - WW'(r_rnd));
            end
            abkf_pkg::CMD_P00_ADD: begin
                r_p00 <= abkf_pkg::sat32(WW'(r_p00) + WW'(r_rnd));
            end
            abkf_pkg::CMD_P11_ADD: begin
                r_p11 <= abkf_pkg::sat32(WW'(r_p11) + WW'(r_rnd));
            end
            abkf_pkg::CMD_DIV_INIT: begin
                r_y       <= abkf_pkg::sat32(WW'(r_meas) - WW'(r_ang));
                r_divisor <= {s_sum[33:0], 1'b0};
                r_neg0    <= r_p00[DW-1];
                r_neg1    <= r_p10[DW-1];
                r_rem0    <= '0;
                r_rem1    <= '0;
                r_dvd0    <= {mag0, 25'd0} + abkf_pkg::DvdW'(s_sum[32:0]);
                r_dvd1    <= {mag1, 25'd0} + abkf_pkg::DvdW'(s_sum[32:0]);
            end
            abkf_pkg::CMD_DIV_STEP: begin
                if (!trial0[abkf_pkg::RemW]) begin
                    r_rem0 <= trial0[abkf_pkg::RemW-1:0];
                end else begin
                    r_rem0 <= {r_rem0[abkf_pkg::RemW-2:0], r_dvd0[abkf_pkg::DvdW-1]};
                end
                r_dvd0 <= {r_dvd0[abkf_pkg::DvdW-2:0], !trial0[abkf_pkg::RemW]};
                if (!trial1[abkf_pkg::RemW]) begin
                    r_rem1 <= trial1[abkf_pkg::RemW-1:0];
                end else begin
                    r_rem1 <= {r_rem1[abkf_pkg::RemW-2:0], r_dvd1[abkf_pkg::DvdW-1]};
                end
                r_dvd1 <= {r_dvd1[abkf_pkg::DvdW-2:0], !trial1[abkf_pkg::RemW]};
            end
            abkf_pkg::CMD_DIV_END: begin
                r_k0 <= gain(r_dvd0, r_neg0);
                r_k1 <= gain(r_dvd1, r_neg1);
            end
            abkf_pkg::CMD_BIAS_ADD: begin
                r_bias <= abkf_pkg::sat32(WW'(r_bias) + WW'(r_rnd));
            end
            abkf_pkg::CMD_P00_SUB: begin
                r_p00 <= abkf_pkg::sat32(WW'(r_p00) - WW'(r_rnd));
            end
            abkf_pkg::CMD_P01_SUB: begin
                r_p01 <= abkf_pkg::sat32(WW'(r_p01) - WW'(r_rnd));
            end
            abkf_pkg::CMD_P10_SUB: begin
                r_p10 <= abkf_pkg::sat32(WW'(r_p10) - WW'(r_rnd));
            end
            abkf_pkg::CMD_P11_SUB: begin
                r_p11 <= abkf_pkg::sat32(WW'(r_p11) - WW'(r_rnd));
            end
            abkf_pkg::CMD_STORE: begin
                r_out_ch   <= r_ch;
                r_out_ang  <= r_ch_ok ? r_ang : '0;
                r_out_rate <= r_ch_ok ? r_rate : '0;
            end
            default: begin
            end
        endcase
    end

    assign o_out_channel    = r_out_ch;
    assign o_angle_estimate = r_out_ang;
    assign o_unbiased_rate  = r_out_rate;

endmodule

// ===== rtl/core/angle_bias_kalman_filter_unit.sv =====
// top level of the two-state angle and gyro bias kalman filter
// a request runs through predict, the gain division in the two parallel divider lanes, and correction
// nonpositive S skips the divider and correction; a channel out of range skips straight to the result
// the next request is taken only once the previous result is registered
// the result register lets a new request start while the previous result waits
// reset: config registers return to defaults, every channel to zero angle/bias and unit covariance
module angle_bias_kalman_filter_unit #(
    parameter int CHANNELS = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_channel,
    input  logic signed [abkf_pkg::DataW-1:0]   i_measured_angle,
    input  logic signed [abkf_pkg::DataW-1:0]   i_measured_rate,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_out_channel,
    output logic signed [abkf_pkg::DataW-1:0]   o_angle_estimate,
    output logic signed [abkf_pkg::DataW-1:0]   o_unbiased_rate,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [abkf_pkg::CfgIdxW-1:0]        i_cfg_index,
    input  logic [abkf_pkg::NoiseW-1:0]         i_cfg_data
);

    abkf_pkg::t_cmd    cmd;
    abkf_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    abkf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    abkf_datapath #(
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_channel        (i_channel),
        .i_measured_angle (i_measured_angle),
        .i_measured_rate  (i_measured_rate),
        .o_out_channel    (o_out_channel),
        .o_angle_estimate (o_angle_estimate),
        .o_unbiased_rate  (o_unbiased_rate)
    );

endmodule

// ===== bench/tb_angle_bias_kalman_filter_unit.sv =====
// testbench of the angle/bias kalman filter: directed and random requests checked against a predictor
module tb_angle_bias_kalman_filter_unit;

    localparam int NumCh = 2;
    localparam int RandItems = 1550;
    localparam int WatchLimit = 20000;

    typedef struct packed {
        logic               ch;
        logic signed [31:0] ang;
        logic signed [31:0] rate;
    } t_req;

    typedef struct packed {
        logic               ch;
        logic signed [31:0] ang;
        logic signed [31:0] rate;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic i_channel = 1'b0;
    logic signed [31:0] i_measured_angle = '0;
    logic signed [31:0] i_measured_rate = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic o_out_channel;
    logic signed [31:0] o_angle_estimate;
    logic signed [31:0] o_unbiased_rate;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [abkf_pkg::CfgIdxW-1:0] i_cfg_index = '0;
    logic [abkf_pkg::NoiseW-1:0] i_cfg_data = '0;

    angle_bias_kalman_filter_unit #(.CHANNELS(NumCh)) dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [24:0] q_ang_r, q_bias_r, r_meas_r;
    logic [16:0] dt_r;
    logic signed [31:0] ang_st[NumCh], bias_st[NumCh];
    logic signed [31:0] paa[NumCh], pab[NumCh], pba[NumCh], pbb[NumCh];

    t_req req_q[$];
    t_res filt_q[$];
    int errors = 0;
    int accepted = 0;
    int results = 0;
    int idle_cycles = 0;
    bit hold_off = 1'b0;
    int hold_cnt = 0;

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint round_rsh(input longint v, input int s);
        longint half;
        half = longint'(1) << (s - 1);
        if (v >= 0) return (v + half) >>> s;
        return -((-v + half) >>> s);
    endfunction

    function automatic logic signed [31:0] gain_q24(input longint n, input longint d);
        longint mag, q;
        mag = (n >= 0) ? n : -n;
        q = ((mag << 25) + d) / (d * 2);
        if (q > 64'sd2147483648) q = 64'sd2147483648;
        return clamp32(n >= 0 ? q : -q);
    endfunction

    task automatic filter_reset();
        q_ang_r = abkf_pkg::QAngleRst;
        q_bias_r = abkf_pkg::QBiasRst;
        r_meas_r = abkf_pkg::RMeasRst;
        dt_r = abkf_pkg::DtRst;
        for (int c = 0; c < NumCh; c++) begin
            ang_st[c] = 0;
            bias_st[c] = 0;
            paa[c] = abkf_pkg::OneQ24;
            pab[c] = 0;
            pba[c] = 0;
            pbb[c] = abkf_pkg::OneQ24;
        end
    endtask

    function automatic t_res filter_update(input t_req r);
        t_res o;
        int c;
        longint dt, dtp11, t, s, y;
        logic signed [31:0] k0, k1, p00, p01, rate;
        c = int'(r.ch);
        dt = dt_r;
        o.ch = r.ch;
        rate = clamp32(longint'(r.rate) - bias_st[c]);
        ang_st[c] = clamp32(longint'(ang_st[c]) + round_rsh(longint'(rate) * dt, 16));
        dtp11 = round_rsh(longint'(pbb[c]) * dt, 16);
        t = dtp11 - pab[c] - pba[c] + longint'(q_ang_r);
        paa[c] = clamp32(longint'(paa[c]) + round_rsh(t * dt, 16));
        pab[c] = clamp32(longint'(pab[c]) - dtp11);
        pba[c] = clamp32(longint'(pba[c]) - dtp11);
        pbb[c] = clamp32(longint'(pbb[c]) + round_rsh(longint'(q_bias_r) * dt, 16));
        s = longint'(paa[c]) + longint'(r_meas_r);
        if (s > 0) begin
            k0 = gain_q24(paa[c], s);
            k1 = gain_q24(pba[c], s);
            y = clamp32(longint'(r.ang) - ang_st[c]);
            ang_st[c] = clamp32(longint'(ang_st[c]) + round_rsh(longint'(k0) * y, 24));
            bias_st[c] = clamp32(longint'(bias_st[c]) + round_rsh(longint'(k1) * y, 24));
            p00 = paa[c];
            p01 = pab[c];
            paa[c] = clamp32(longint'(paa[c]) - round_rsh(longint'(k0) * p00, 24));
            pab[c] = clamp32(longint'(pab[c]) - round_rsh(longint'(k0) * p01, 24));
            pba[c] = clamp32(longint'(pba[c]) - round_rsh(longint'(k1) * p00, 24));
            pbb[c] = clamp32(longint'(pbb[c]) - round_rsh(longint'(k1) * p01, 24));
        end
        o.ang = ang_st[c];
        o.rate = rate;
        return o;
    endfunction

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(0, 2000)) - 1000;
            3: return $signed($urandom_range(0, 32'h00400000)) - 32'sh00200000;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_req(input logic ch, input logic signed [31:0] a,
                            input logic signed [31:0] r);
        t_req q;
        q.ch = ch;
        q.ang = a;
        q.rate = r;
        req_q.push_back(q);
    endtask

    // waits until every queued request has its result back
    task automatic drain();
        while (req_q.size() != 0 || i_in_valid || filt_q.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [abkf_pkg::CfgIdxW-1:0] idx,
                             input logic [24:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            abkf_pkg::RegQAngle: q_ang_r = val;
            abkf_pkg::RegQBias: q_bias_r = val;
            abkf_pkg::RegRMeas: r_meas_r = val;
            abkf_pkg::RegDt: dt_r = val[16:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // driver
    int in_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                filt_q.push_back(filter_update('{i_channel, i_measured_angle,
                                                 i_measured_rate}));
                accepted++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (req_q.size() != 0) begin
                    t_req q;
                    q = req_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_channel <= q.ch;
                    i_measured_angle <= q.ang;
                    i_measured_rate <= q.rate;
                    in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int out_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                t_res e;
                results++;
                if (filt_q.size() == 0) begin
                    $display("%0t: unexpected result ch=%0d ang=%0d rate=%0d", $time,
                             o_out_channel, o_angle_estimate, o_unbiased_rate);
                    errors++;
                end else begin
                    e = filt_q.pop_front();
                    if (o_out_channel !== e.ch) begin
                        $display("%0t: channel exp %0d got %0d", $time, e.ch, o_out_channel);
                        errors++;
                    end
                    if (o_angle_estimate !== e.ang) begin
                        $display("%0t: angle exp %0d got %0d", $time, e.ang,
                                 o_angle_estimate);
                        errors++;
                    end
                    if (o_unbiased_rate !== e.rate) begin
                        $display("%0t: rate exp %0d got %0d", $time, e.rate,
                                 o_unbiased_rate);
                        errors++;
                    end
                end
                out_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
                i_out_ready <= 1'b0;
            end else if (hold_off) begin
                i_out_ready <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // long receiver hold-off while requests keep coming
    always @(posedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            if (hold_cnt == 1) hold_off <= 1'b0;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit) begin
            $display("timeout waiting for handshake");
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0)
                push_req(1'($urandom_range(0, 1)), rand_word(), rand_word());
            else
                push_req(1'($urandom_range(0, 1)),
                         $signed($urandom_range(0, 32'h00B40000)) - 32'sh005A0000,
                         $signed($urandom_range(0, 32'h00200000)) - 32'sh00100000);
        end
    endtask

    initial begin
        filter_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes on both channels
        push_req(1'b0, 32'sd0, 32'sd0);
        push_req(1'b1, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        push_req(1'b0, 32'sh80000000, 32'sh80000000);
        push_req(1'b1, 32'sh80000000, 32'sh7FFFFFFF);
        push_req(1'b0, 32'sh7FFFFFFF, 32'sh80000000);
        push_req(1'b1, 32'sh00010000, -32'sh00010000);
        push_req(1'b0, -32'sd1, 32'sd1);
        push_req(1'b1, 32'sh55555555, 32'shAAAAAAAA);
        push_req(1'b0, 32'shAAAAAAAA, 32'sh55555555);
        drain();

        // config extremes: zero noise, tiny r, a step of 65536
        write_reg(abkf_pkg::RegQAngle, 25'd0);
        write_reg(abkf_pkg::RegQBias, 25'd0);
        write_reg(abkf_pkg::RegRMeas, 25'd1);
        write_reg(abkf_pkg::RegDt, 25'd65536);
        push_req(1'b0, 32'sh7FFFFFFF, 32'sh80000000);
        push_req(1'b1, 32'sh00100000, 32'sh00020000);
        push_req(1'b0, 32'sh80000000, 32'sh7FFFFFFF);
        push_req(1'b1, 32'sh80000000, 32'sh7FFFFFFF);
        drain();

        // large noise so covariance saturates and S may go nonpositive
        write_reg(abkf_pkg::RegQAngle, 25'h1000000);
        write_reg(abkf_pkg::RegQBias, 25'h1000000);
        write_reg(abkf_pkg::RegRMeas, 25'h1000000);
        write_reg(abkf_pkg::RegDt, 25'd1);
        for (int i = 0; i < 6; i++) push_req(i[0], 32'sh7FFFFFFF, 32'sh80000000);
        drain();
        write_reg(abkf_pkg::RegQAngle, 25'h1FFFFFF);
        write_reg(abkf_pkg::RegDt, 25'h1FFFF);
        for (int i = 0; i < 6; i++) push_req(i[0], rand_word(), rand_word());
        drain();

        // back to defaults, then fill the block while the receiver holds off
        write_reg(abkf_pkg::RegQAngle, abkf_pkg::QAngleRst);
        write_reg(abkf_pkg::RegQBias, abkf_pkg::QBiasRst);
        write_reg(abkf_pkg::RegRMeas, abkf_pkg::RMeasRst);
        write_reg(abkf_pkg::RegDt, 25'(abkf_pkg::DtRst));
        hold_off = 1'b1;
        hold_cnt <= 600;
        random_phase(20);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            write_reg(abkf_pkg::RegQAngle, 25'($urandom_range(0, 25'h1FFFFFF)));
            write_reg(abkf_pkg::RegQBias, 25'($urandom_range(0, 25'h100000)));
            write_reg(abkf_pkg::RegRMeas, 25'($urandom_range(1, 25'h1000000)));
            write_reg(abkf_pkg::RegDt, 25'($urandom_range(1, 65536)));
            random_phase(RandItems / 5);
            drain();
        end

        $display("%0d requests accepted, %0d results checked, config swept over extremes",
                 accepted, results);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
